### sv/iib_pkg.sv
`timescale 1ns / 1ps
package iib_pkg;

  localparam int IMAGE_WIDTH  = 320;
  localparam int IMAGE_HEIGHT = 240;

  localparam int COL_BITS = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
  localparam int ROW_BITS = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;

  localparam int PIX_W    = 8;
  localparam int XF_W     = 10;
  localparam int COLSUM_W = 17;
  localparam int SUM_W    = 26;
  localparam int IDX_W    = 1;

  localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(IMAGE_WIDTH - 1);
  localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(IMAGE_HEIGHT - 1);

  localparam logic [IDX_W-1:0] REG_DIFF_MODE  = 1'b0;
  localparam logic [IDX_W-1:0] REG_GRAY_VALUE = 1'b1;

  typedef struct packed {
    logic             diff_mode;
    logic [PIX_W-1:0] gray_value;
  } cfg_t;

endpackage

### sv/iib_pix_if.sv
`timescale 1ns / 1ps
interface iib_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

### sv/iib_sum_if.sv
`timescale 1ns / 1ps
interface iib_sum_if;
  logic        valid;
  logic        ready;
  logic [25:0] integral_sum;
  logic        last_in_row;
  logic        last_in_frame;

  modport source (output valid, output integral_sum, output last_in_row,
                  output last_in_frame, input ready);
  modport sink (input valid, input integral_sum, input last_in_row,
                input last_in_frame, output ready);
endinterface

### sv/iib_cfg_if.sv
`timescale 1ns / 1ps
interface iib_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/iib_xform.sv
`timescale 1ns / 1ps
module iib_xform (
  input  iib_pkg::cfg_t             cfg,
  input  logic [iib_pkg::PIX_W-1:0] pixel,
  output logic [iib_pkg::XF_W-1:0]  value
);
  import iib_pkg::*;

  logic [PIX_W-1:0] delta;
  logic             brighter;

  always_comb begin
    brighter = pixel > cfg.gray_value;
    delta = brighter ? (pixel - cfg.gray_value) : (cfg.gray_value - pixel);
    if (!cfg.diff_mode) begin
      value = XF_W'(pixel);
    end else if (brighter) begin
      value = XF_W'(delta);
    end else begin
      // darker: a + 2*floor(a/2), equal gives zero by itself
      value = XF_W'(delta) + XF_W'({delta[PIX_W-1:1], 1'b0});
    end
  end

endmodule

### sv/integral_image_builder_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields                                       Handshake
// pix_in    in   pixel[7:0]                                   valid/ready
// sum_out   out  integral_sum[25:0], last_in_row, last_in_frame valid/ready
// cfg       in   index[0:0] (0 diff_mode, 1 gray_value), data[7:0] valid/ready
//
// One pixel per clock unless the output stalls; pixels pass stage 1, stage 2 and the output.
// The column sums live in a 320 x 17 line store with registered reads;
// the pixel ahead is forwarded when it writes the column just being read.
// rst clears positions, the row sum, pipeline valids and the registers; the line
// store needs no clearing since row zero never reads it.
// A stalled output holds its word; the two inner stages keep accepting until full.
module integral_image_builder_top (
  input logic       clk,
  input logic       rst,
  iib_pix_if.sink   pix_in,
  iib_sum_if.source sum_out,
  iib_cfg_if.sink   cfg
);
  import iib_pkg::*;

  cfg_t cfg_regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DIFF_MODE:  cfg_regs.diff_mode  <= cfg.data[0];
        REG_GRAY_VALUE: cfg_regs.gray_value <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input side: raster position and transform
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic [XF_W-1:0]     xf_value;
  logic                accept;
  logic                end_row;
  logic                end_frame;

  iib_xform u_xform (
    .cfg   (cfg_regs),
    .pixel (pix_in.pixel),
    .value (xf_value)
  );

  assign end_row   = col == LAST_COL;
  assign end_frame = end_row && (row == LAST_ROW);

  // Pipeline enables
  logic s1_valid, s2_valid;
  logic en_out, en2, en1;

  assign en_out       = !sum_out.valid || sum_out.ready;
  assign en2          = !s2_valid || en_out;
  assign en1          = !s1_valid || en2;
  assign pix_in.ready = en1;
  assign accept       = pix_in.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (end_row) begin
        col <= '0;
        row <= end_frame ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Stage 1: line store read returns, column sum formed and written back
  logic [COLSUM_W-1:0] line_mem [IMAGE_WIDTH];
  logic [COLSUM_W-1:0] rd_data;
  logic [COLSUM_W-1:0] fwd_data;
  logic [COLSUM_W-1:0] above;
  logic [COLSUM_W-1:0] colsum;
  logic [XF_W-1:0]     s1_value;
  logic [COL_BITS-1:0] s1_col;
  logic                s1_row0;
  logic                s1_fwd;
  logic                s1_end_row;
  logic                s1_end_frame;
  logic                wr_en;

  assign wr_en = s1_valid && en2;

  always_comb begin
    if (s1_row0) begin
      above = '0;
    end else if (s1_fwd) begin
      above = fwd_data;
    end else begin
      above = rd_data;
    end
    colsum = above + COLSUM_W'(s1_value);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_col] <= colsum;
    end
    if (accept) begin
      rd_data <= line_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value     <= xf_value;
      s1_col       <= col;
      s1_row0      <= row == '0;
      // word ahead writes this column in the same cycle: take its sum directly
      s1_fwd       <= wr_en && (s1_col == col);
      fwd_data     <= colsum;
      s1_end_row   <= end_row;
      s1_end_frame <= end_frame;
    end
  end

  // Stage 2: column sum waits for the row accumulator
  logic [COLSUM_W-1:0] s2_colsum;
  logic                s2_end_row;
  logic                s2_end_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      s2_colsum    <= colsum;
      s2_end_row   <= s1_end_row;
      s2_end_frame <= s1_end_frame;
    end
  end

  // Output stage: row accumulator and result register
  logic [SUM_W-1:0] row_sum;
  logic [SUM_W-1:0] total;
  logic             load_out;

  assign total    = row_sum + SUM_W'(s2_colsum);
  assign load_out = s2_valid && en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum       <= '0;
      sum_out.valid <= 1'b0;
    end else begin
      if (en_out) begin
        sum_out.valid <= s2_valid;
      end
      if (load_out) begin
        row_sum <= s2_end_row ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sum_out.integral_sum  <= total;
      sum_out.last_in_row   <= s2_end_row;
      sum_out.last_in_frame <= s2_end_frame;
    end
  end

endmodule

### tb/integral_image_builder_top_test.sv
`timescale 1ns / 1ps
module integral_image_builder_top_test;
  import iib_pkg::*;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             row_end;
    logic             frame_end;
  } sum_word_t;

  logic clk;
  logic rst;

  iib_pix_if pix_if ();
  iib_sum_if sum_if ();
  iib_cfg_if cfg_if ();

  integral_image_builder_top uut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_if),
    .sum_out (sum_if),
    .cfg     (cfg_if)
  );

  logic [PIX_W-1:0] pixel_queue[$];
  sum_word_t        expected_sums[$];

  // Predictor state
  logic [COLSUM_W-1:0] col_store[IMAGE_WIDTH];
  logic [SUM_W-1:0]    row_acc;
  int                  col_pos;
  int                  row_pos;
  cfg_t                cfg_mirror;

  int send_idle_pct;
  int recv_idle_pct;
  int pix_gap;
  int recv_wait;
  int pushed_count;
  int error_count;
  int sums_checked;
  int rows_seen;
  int frames_seen;
  int settings_count;

  function automatic int draw_gap(int pct);
    if ($urandom_range(99) < pct) return $urandom_range(9);
    return 0;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 25;
      2: return 60;
      default: return 100;
    endcase
  endfunction

  function automatic logic [XF_W-1:0] weigh_pixel(logic [PIX_W-1:0] px);
    logic [XF_W-1:0] a;
    if (!cfg_mirror.diff_mode) return XF_W'(px);
    if (px > cfg_mirror.gray_value) return XF_W'(px) - XF_W'(cfg_mirror.gray_value);
    if (px == cfg_mirror.gray_value) return '0;
    // darker side weighs the even part of the distance twice over
    a = XF_W'(cfg_mirror.gray_value) - XF_W'(px);
    return XF_W'(a + 2 * (a >> 1));
  endfunction

  function automatic sum_word_t integrate_pixel(logic [PIX_W-1:0] px);
    logic [COLSUM_W-1:0] above;
    logic [COLSUM_W-1:0] colsum;
    sum_word_t           w;
    above = (row_pos == 0) ? '0 : col_store[col_pos];
    colsum = above + COLSUM_W'(weigh_pixel(px));
    col_store[col_pos] = colsum;
    w.sum = row_acc + SUM_W'(colsum);
    w.row_end = (col_pos == IMAGE_WIDTH - 1);
    w.frame_end = w.row_end && (row_pos >= IMAGE_HEIGHT - 1);
    if (w.row_end) begin
      row_acc = '0;
      col_pos = 0;
      row_pos = w.frame_end ? 0 : row_pos + 1;
    end else begin
      row_acc = w.sum;
      col_pos = col_pos + 1;
    end
    return w;
  endfunction

  task automatic flag_error(string msg);
    if (error_count < 30) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: one pixel word per handshake, with a drawn gap after each
  always @(posedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
      pix_gap <= 0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (pix_gap != 0) begin
        pix_if.valid <= 1'b0;
        pix_gap <= pix_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        pix_if.valid <= 1'b1;
        pix_if.pixel <= pixel_queue.pop_front();
        pix_gap <= draw_gap(send_idle_pct);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted pixels, check accepted sums, stall the output
  always @(posedge clk) begin
    sum_word_t want;
    int        w;
    if (rst) begin
      sum_if.ready <= 1'b0;
      recv_wait <= 0;
      row_acc = '0;
      col_pos = 0;
      row_pos = 0;
      cfg_mirror = '0;
    end else begin
      if (pix_if.valid && pix_if.ready)
        expected_sums.push_back(integrate_pixel(pix_if.pixel));
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_DIFF_MODE:  cfg_mirror.diff_mode = cfg_if.data[0];
          REG_GRAY_VALUE: cfg_mirror.gray_value = cfg_if.data;
          default: ;
        endcase
      end
      if (sum_if.valid && sum_if.ready) begin
        if (expected_sums.size() == 0) begin
          flag_error($sformatf("sum %0d arrived with nothing expected", sum_if.integral_sum));
        end else begin
          want = expected_sums.pop_front();
          if (sum_if.integral_sum !== want.sum)
            flag_error($sformatf("word %0d: integral_sum %0d, expected %0d",
                                 sums_checked, sum_if.integral_sum, want.sum));
          if (sum_if.last_in_row !== want.row_end)
            flag_error($sformatf("word %0d: last_in_row %b, expected %b",
                                 sums_checked, sum_if.last_in_row, want.row_end));
          if (sum_if.last_in_frame !== want.frame_end)
            flag_error($sformatf("word %0d: last_in_frame %b, expected %b",
                                 sums_checked, sum_if.last_in_frame, want.frame_end));
          if (want.row_end) rows_seen++;
          if (want.frame_end) frames_seen++;
        end
        sums_checked++;
        w = draw_gap(recv_idle_pct);
        recv_wait <= w;
        sum_if.ready <= (w == 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        sum_if.ready <= (recv_wait == 1);
      end else begin
        sum_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_pixel(logic [PIX_W-1:0] px);
    pixel_queue.push_back(px);
    pushed_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pix_if.valid || expected_sums.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold the sender until the block is empty, then load both registers
  task automatic apply_setting(logic diff, logic [7:0] gray);
    logic [7:0] d;
    wait_drained();
    d = 8'($urandom);
    d[0] = diff;
    write_reg(REG_DIFF_MODE, d);
    write_reg(REG_GRAY_VALUE, gray);
    send_idle_pct = pick_idle_pct();
    recv_idle_pct = pick_idle_pct();
    settings_count++;
  endtask

  task automatic run_random(int n, logic [7:0] gray);
    int v;
    repeat (n) begin
      case ($urandom_range(7))
        0: v = 0;
        1: v = 255;
        2, 3: begin
          // land on, just above and just below the gray level
          v = int'(gray) + int'($urandom_range(6)) - 3;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        default: v = $urandom_range(255);
      endcase
      push_pixel(PIX_W'(v));
    end
  endtask

  initial begin
    int         waited;
    logic [7:0] gray;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    send_idle_pct = 50;
    recv_idle_pct = 50;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Raw sums at reset settings, starting on row zero
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h55);
    push_pixel(8'hAA);
    push_pixel(8'h0F);
    push_pixel(8'hF0);
    push_pixel(8'h01);
    push_pixel(8'h80);

    // Distance mode around mid gray: equal, brighter, darker odd and even
    apply_setting(1'b1, 8'd128);
    push_pixel(8'd128);
    push_pixel(8'd129);
    push_pixel(8'd127);
    push_pixel(8'd126);
    push_pixel(8'd125);
    push_pixel(8'd0);
    push_pixel(8'd255);

    apply_setting(1'b1, 8'd0);
    push_pixel(8'd0);
    push_pixel(8'd255);
    push_pixel(8'd1);

    apply_setting(1'b1, 8'd255);
    push_pixel(8'd0);
    push_pixel(8'd255);
    push_pixel(8'd254);
    push_pixel(8'd1);

    gray = 8'($urandom);
    apply_setting(1'b0, gray);
    run_random(200, gray);
    apply_setting(1'b1, 8'd0);
    run_random(200, 8'd0);
    apply_setting(1'b1, 8'd255);
    run_random(200, 8'd255);
    gray = 8'($urandom);
    apply_setting(1'b1, gray);
    run_random(200, gray);
    apply_setting(1'b0, 8'd255);
    run_random(200, 8'd255);

    gray = 8'($urandom);
    apply_setting(1'b0, gray);
    run_random(225, gray);
    gray = 8'($urandom);
    apply_setting(1'b1, gray);
    run_random(225, gray);

    waited = 0;
    while ((pixel_queue.size() != 0 || pix_if.valid || expected_sums.size() != 0)
           && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_sums.size() != 0)
      flag_error($sformatf("%0d sums never arrived", expected_sums.size()));

    $display("Checked %0d sums from %0d pixels over %0d register settings.",
             sums_checked, pushed_count, settings_count);
    $display("Saw %0d row ends and %0d frame ends, raw and distance modes, both sides stalling.",
             rows_seen, frames_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
